@@ hdl/decimal_text_to_int32_checker_core_defines.svh @@
// Assertion macros shared by the checker RTL.
`ifndef DECIMAL_TEXT_TO_INT32_CHECKER_CORE_DEFINES_SVH
`define DECIMAL_TEXT_TO_INT32_CHECKER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DTTI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DTTI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/dtti_pkg.sv @@
package dtti_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_RANGE   = 2'd2
  } status_e;

  // Magnitude limits for the two signs
  localparam logic [31:0] MaxPosMag = 32'h7FFF_FFFF;
  localparam logic [31:0] MaxNegMag = 32'h8000_0000;

  // Digit count limit and saturation value
  localparam logic [3:0] MaxDigits = 4'd10;
  localparam logic [3:0] CountSat  = 4'hF;

  // ASCII codes
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

endpackage

@@ hdl/decimal_text_to_int32_checker_core.sv @@
// Result path: the last character of a string is accepted into the input register, and
// its result loads into the result register when the held character advances.
// Throughput: one character per cycle; the multiply-by-ten accumulate is a
// combinational shift-add, and a last character waits only while the previous result is held.
// Reset: rst_ni clears the accumulated string state and both valid flags.
`include "decimal_text_to_int32_checker_core_defines.svh"

module decimal_text_to_int32_checker_core
  import dtti_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         character_i,
  input  logic               last_char_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] value_o,
  output logic [1:0]         status_o
);

  // Input register
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_char_q;
  logic       s1_last_q;
  logic       s1_go;
  logic       in_accept;

  // String state
  logic [31:0] mag_q, mag_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d;
  logic        bad_q, bad_d;
  logic        first_q, first_d;

  // Result register
  logic        out_valid_q, out_valid_d;
  logic [31:0] value_q, value_d;
  status_e     status_q, status_d;

  // Step logic
  logic        is_minus, is_digit;
  logic [7:0]  digit_full;
  logic [35:0] prod;
  logic [31:0] mag_upd, limit;
  logic [3:0]  cnt_upd;
  logic        neg_upd, bad_upd;

  // Advance the held character unless its result cannot be stored
  assign s1_go      = s1_valid_q && (!s1_last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;
  assign in_accept  = in_valid_i && in_ready_o;
  assign s1_valid_d = in_accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_q);

  // Classify the character and accumulate the magnitude
  always_comb begin
    is_minus   = first_q && (s1_char_q == CharMinus);
    is_digit   = (s1_char_q >= CharZero) && (s1_char_q <= CharNine);
    digit_full = s1_char_q - CharZero;
    prod       = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1) + {28'b0, digit_full};
    mag_upd    = mag_q;
    cnt_upd    = cnt_q;
    neg_upd    = neg_q;
    bad_upd    = bad_q;
    if (is_minus) begin
      neg_upd = 1'b1;
    end else if (is_digit) begin
      mag_upd = (prod[35:32] != 4'b0) ? '1 : prod[31:0];
      cnt_upd = (cnt_q == CountSat) ? cnt_q : cnt_q + 4'd1;
    end else begin
      bad_upd = 1'b1;
    end
  end

  // Check the finished string and form its result
  always_comb begin
    limit   = neg_upd ? MaxNegMag : MaxPosMag;
    value_d = '0;
    if (bad_upd || (cnt_upd == 4'd0)) begin
      status_d = ST_INVALID;
    end else if ((cnt_upd > MaxDigits) || (mag_upd > limit)) begin
      status_d = ST_RANGE;
    end else begin
      status_d = ST_OK;
      value_d  = neg_upd ? (32'd0 - mag_upd) : mag_upd;
    end
  end

  // Next string state: keep accumulating, or drop back to reset after the last item
  always_comb begin
    mag_d   = mag_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    bad_d   = bad_q;
    first_d = first_q;
    if (s1_go) begin
      if (s1_last_q) begin
        mag_d   = '0;
        cnt_d   = '0;
        neg_d   = 1'b0;
        bad_d   = 1'b0;
        first_d = 1'b1;
      end else begin
        mag_d   = mag_upd;
        cnt_d   = cnt_upd;
        neg_d   = neg_upd;
        bad_d   = bad_upd;
        first_d = 1'b0;
      end
    end
  end

  // Hold the result until taken
  assign out_valid_d = (s1_go && s1_last_q) ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // Control and string state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mag_q       <= '0;
      cnt_q       <= '0;
      neg_q       <= 1'b0;
      bad_q       <= 1'b0;
      first_q     <= 1'b1;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      mag_q       <= mag_d;
      cnt_q       <= cnt_d;
      neg_q       <= neg_d;
      bad_q       <= bad_d;
      first_q     <= first_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_char_q <= character_i;
      s1_last_q <= last_char_i;
    end
    if (s1_go && s1_last_q) begin
      value_q  <= value_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

  // Checks
  `DTTI_ASSERT_SAME(a_err_value_zero, clk_i, rst_ni,
                    out_valid_q && (status_q != ST_OK), value_q == 32'd0,
                    "nonzero value with error status")
  `DTTI_ASSERT_NEXT(a_state_cleared, clk_i, rst_ni,
                    s1_go && s1_last_q,
                    first_q && (mag_q == 32'd0) && (cnt_q == 4'd0) && !neg_q && !bad_q,
                    "string state not cleared after last item")
  `DTTI_ASSERT_SAME(a_result_source, clk_i, rst_ni,
                    $rose(out_valid_q), $past(s1_go && s1_last_q),
                    "result raised without a last item")
  `DTTI_ASSERT_SAME(a_stall_cause, clk_i, rst_ni,
                    !in_ready_o, s1_valid_q && s1_last_q && out_valid_q && !out_ready_i,
                    "input stalled without a blocked result")

endmodule
